@@ hw/rtl/prfd_pkg.sv @@
// Package for the padded reply frame deframer: framing bytes, status codes
// and the request/result item types. No dependencies.
`default_nettype none

package prfd_pkg;

   localparam logic [7:0] HeaderByte     = 8'h41;
   localparam logic [7:0] TrailerByte    = 8'h10;
   localparam logic [7:0] PadByte        = 8'h00;
   localparam logic [7:0] TimeoutLen     = 8'hFF;
   localparam logic [7:0] MaxLengthReset = 8'hFF;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   // CSR word index (paddr[2])
   localparam logic CsrIdxMaxLength = 1'b0;

   typedef enum logic [2:0] {
      STATUS_BYTE    = 3'd0,
      STATUS_DONE    = 3'd1,
      STATUS_TIMEOUT = 3'd2,
      STATUS_TOOLONG = 3'd3,
      STATUS_PADDING = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       timed_out;
   } req_item_type;

   typedef struct packed {
      status_type status;
      logic [7:0] payload;
      logic [7:0] frame_length;
      logic       last;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ hw/rtl/prfd_if.sv @@
// Valid/ready channel interfaces for deframer requests and results.
// Depends on prfd_pkg for the status type.
`default_nettype none

interface prfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       timed_out;

   modport source (output valid, output rx_byte, output timed_out, input ready);
   modport sink (input valid, input rx_byte, input timed_out, output ready);
endinterface

interface prfd_rsp_if;
   logic                 valid;
   logic                 ready;
   prfd_pkg::status_type status;
   logic [7:0]           payload;
   logic [7:0]           frame_length;
   logic                 last;

   modport source (output valid, output status, output payload, output frame_length,
                   output last, input ready);
   modport sink (input valid, input status, input payload, input frame_length,
                 input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/prfd_csr.sv @@
// APB-style register block holding max_length.
// Depends on prfd_pkg for address/data widths and reset value.
`default_nettype none

module prfd_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [prfd_pkg::CsrAddrWidth-1:0] paddr,
   input  wire logic [prfd_pkg::CsrDataWidth-1:0] pwdata,
   output logic      [prfd_pkg::CsrDataWidth-1:0] prdata,
   output logic                                   pready,
   output logic      [7:0]                        max_length
);

   logic [7:0] max_length_ff;
   logic [7:0] max_length_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      max_length_in = max_length_ff;
      if (wr_en && (paddr[2] == prfd_pkg::CsrIdxMaxLength)) begin
         max_length_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= prfd_pkg::MaxLengthReset;
      end else begin
         max_length_ff <= max_length_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == prfd_pkg::CsrIdxMaxLength) begin
         prdata = {{(prfd_pkg::CsrDataWidth-8){1'b0}}, max_length_ff};
      end
   end

   assign max_length = max_length_ff;

endmodule

`default_nettype wire

@@ hw/rtl/prfd_fsm.sv @@
// Frame state machine: phase, remaining count and length; computes the
// result of one request combinationally. Depends on prfd_pkg.
`default_nettype none

module prfd_fsm (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire prfd_pkg::req_item_type item,
   input  wire logic [7:0]             max_length,
   output logic                        has_result,
   output prfd_pkg::rsp_item_type      result
);

   typedef enum logic [4:0] {
      PHASE_HUNT    = 5'b00001,
      PHASE_LEN     = 5'b00010,
      PHASE_DATA    = 5'b00100,
      PHASE_PAD     = 5'b01000,
      PHASE_TRAILER = 5'b10000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] length_seen_ff, length_seen_in;
   logic [7:0] len;

   assign len = item.timed_out ? prfd_pkg::TimeoutLen : item.rx_byte;

   always_comb begin
      phase_in       = phase_ff;
      remaining_in   = remaining_ff;
      length_seen_in = length_seen_ff;
      has_result     = 1'b0;
      result         = '{status: prfd_pkg::STATUS_BYTE, payload: 8'd0,
                         frame_length: 8'd0, last: 1'b0};
      case (phase_ff)
         PHASE_LEN: begin
            if (len > max_length) begin
               phase_in      = PHASE_HUNT;
               remaining_in  = 8'd0;
               has_result    = 1'b1;
               result.status = prfd_pkg::STATUS_TOOLONG;
               result.last   = 1'b1;
            end else begin
               length_seen_in = len;
               remaining_in   = len;
               phase_in       = (len == 8'd0) ? PHASE_TRAILER : PHASE_DATA;
            end
         end
         PHASE_DATA: begin
            has_result = 1'b1;
            if (item.timed_out) begin
               phase_in      = PHASE_HUNT;
               remaining_in  = 8'd0;
               result.status = prfd_pkg::STATUS_TIMEOUT;
               result.last   = 1'b1;
            end else begin
               phase_in       = PHASE_PAD;
               result.payload = item.rx_byte;
            end
         end
         PHASE_PAD: begin
            if (item.timed_out || (item.rx_byte != prfd_pkg::PadByte)) begin
               phase_in      = PHASE_HUNT;
               remaining_in  = 8'd0;
               has_result    = 1'b1;
               result.status = prfd_pkg::STATUS_PADDING;
               result.last   = 1'b1;
            end else begin
               remaining_in = remaining_ff - 8'd1;
               phase_in     = (remaining_ff == 8'd1) ? PHASE_TRAILER : PHASE_DATA;
            end
         end
         PHASE_TRAILER: begin
            has_result   = 1'b1;
            phase_in     = PHASE_HUNT;
            remaining_in = 8'd0;
            result.last  = 1'b1;
            if (item.timed_out || (item.rx_byte != prfd_pkg::TrailerByte)) begin
               // no separate code for a bad trailer
               result.status = prfd_pkg::STATUS_TIMEOUT;
            end else begin
               result.status       = prfd_pkg::STATUS_DONE;
               result.frame_length = length_seen_ff;
            end
         end
         default: begin
            // hunting; unknown codes fall here too
            phase_in = PHASE_HUNT;
            if (item.timed_out) begin
               remaining_in  = 8'd0;
               has_result    = 1'b1;
               result.status = prfd_pkg::STATUS_TIMEOUT;
               result.last   = 1'b1;
            end else if (item.rx_byte == prfd_pkg::HeaderByte) begin
               phase_in = PHASE_LEN;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_HUNT;
         remaining_ff   <= 8'd0;
         length_seen_ff <= 8'd0;
      end else if (step) begin
         phase_ff       <= phase_in;
         remaining_ff   <= remaining_in;
         length_seen_ff <= length_seen_in;
      end
   end

   a_hunt_no_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_HUNT) |-> (remaining_ff == 8'd0))
      else $error("remaining count nonzero while hunting");

   a_data_has_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_DATA) |-> (remaining_ff != 8'd0))
      else $error("data phase with no bytes remaining");

   a_last_pad_to_trailer: assert property (@(posedge clock) disable iff (reset)
      (step && (phase_ff == PHASE_PAD) && !item.timed_out &&
       (item.rx_byte == prfd_pkg::PadByte) && (remaining_ff == 8'd1))
      |=> (phase_ff == PHASE_TRAILER))
      else $error("final pad did not move to trailer");

endmodule

`default_nettype wire

@@ hw/rtl/padded_reply_frame_deframer.sv @@
// Padded reply frame deframer, top level: request register, frame FSM,
// result register and CSR port. Depends on prfd_pkg, prfd_if, prfd_csr, prfd_fsm.
// The result of a held request, if any, enters the result register when the FSM steps.
// Throughput: one request per cycle while results are drained; the request register and the result
// register decouple the two channels, so a request can be taken while a result waits.
// Reset: synchronous, active high; FSM hunts for the header, max_length = 255.
`default_nettype none

module padded_reply_frame_deframer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   prfd_req_if.sink                               req_ch,
   prfd_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [prfd_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [prfd_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic      [prfd_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                                   csr_pready
);

   // request register
   logic                   in_valid_ff, in_valid_in;
   prfd_pkg::req_item_type in_ff;

   // result register
   logic                   out_valid_ff, out_valid_in;
   prfd_pkg::rsp_item_type out_ff;

   logic                   req_fire;
   logic                   step;
   logic                   has_result;
   prfd_pkg::rsp_item_type result;
   logic [7:0]             max_length;

   prfd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .max_length (max_length)
   );

   prfd_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (in_ff),
      .max_length (max_length),
      .has_result (has_result),
      .result     (result)
   );

   // The held request is processed when it makes no result, or when the
   // result register is empty or being drained this cycle.
   assign step     = in_valid_ff && (!has_result || !out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step;
   assign req_fire = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (step && has_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= '{rx_byte: req_ch.rx_byte, timed_out: req_ch.timed_out};
      end
      if (step && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = out_ff.status;
   assign rsp_ch.payload      = out_ff.payload;
   assign rsp_ch.frame_length = out_ff.frame_length;
   assign rsp_ch.last         = out_ff.last;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !out_valid_ff)
      else $error("result valid after reset");

   a_byte_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.last) |-> (out_ff.status == prfd_pkg::STATUS_BYTE))
      else $error("non-last result is not a payload byte");

   a_no_result_lost: assert property (@(posedge clock) disable iff (reset)
      (step && has_result) |-> (!out_valid_ff || rsp_ch.ready))
      else $error("result overwrote an undelivered result");

endmodule

`default_nettype wire
